// ===== sv/ppa_pkg.sv =====
// Shared types and constants for the parallel port adapter.
package ppa_pkg;

   localparam int unsigned CTL_W = 6;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_PINS  = 2'd2;

   localparam logic [1:0] SEL_PORT_A = 2'd0;
   localparam logic [1:0] SEL_CTL_A  = 2'd1;
   localparam logic [1:0] SEL_PORT_B = 2'd2;
   localparam logic [1:0] SEL_CTL_B  = 2'd3;

   // control register bit positions
   localparam int unsigned CTL_C1_EN   = 0;
   localparam int unsigned CTL_C1_RISE = 1;
   localparam int unsigned CTL_DATA    = 2;
   localparam int unsigned CTL_C2_EN   = 3;
   localparam int unsigned CTL_C2_RISE = 4;
   localparam int unsigned CTL_C2_OUT  = 5;

   // C2 output modes, control bits 5..3
   localparam logic [2:0] C2_STROBE = 3'b100;
   localparam logic [2:0] C2_LOW    = 3'b110;
   localparam logic [2:0] C2_HIGH   = 3'b111;
   localparam logic [1:0] C2_STROBE_ANY = 2'b10;

   typedef struct packed {
      logic [1:0] command;
      logic [1:0] reg_select;
      logic [7:0] write_data;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
      logic       ca1_level;
      logic       cb1_level;
      logic       ca2_level;
      logic       cb2_level;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_latch;
      logic [7:0] port_a_direction;
      logic [7:0] port_b_latch;
      logic [7:0] port_b_direction;
      logic       ca2_drive;
      logic       cb2_drive;
      logic       irq_a_line;
      logic       irq_b_line;
   } rsp_type;

   typedef struct packed {
      logic rd_data;
      logic rd_ctl;
      logic wr_data;
      logic wr_ctl;
      logic pin_update;
      logic strobe;
   } port_op_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] latch;
      logic [7:0] dir;
      logic       c2_drive;
      logic       irq;
   } port_out_type;

endpackage

// ===== sv/ppa_port.sv =====
// One port: latch, direction, control, C1/C2 edge flags and C2 drive.
module ppa_port (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  ppa_pkg::port_op_type op,
   input  logic [7:0]           write_data,
   input  logic [7:0]           pins,
   input  logic                 l1,
   input  logic                 l2,
   output ppa_pkg::port_out_type res
);
   import ppa_pkg::*;

   logic [7:0]       latch_ff, latch_in;
   logic [7:0]       dir_ff, dir_in;
   logic [CTL_W-1:0] ctl_ff, ctl_in;
   logic             drive_ff, drive_in;
   logic             prev1_ff, prev1_in;
   logic             prev2_ff, prev2_in;
   logic             flag1_ff, flag1_in;
   logic             flag2_ff, flag2_in;

   logic sel_latch, edge1, edge2, clear_flags;
   logic [7:0] rd;

   assign sel_latch   = ctl_ff[CTL_DATA];
   assign edge1       = (prev1_ff != l1) && (l1 == ctl_ff[CTL_C1_RISE]);
   assign edge2       = (prev2_ff != l2) && !ctl_ff[CTL_C2_OUT]
                        && (l2 == ctl_ff[CTL_C2_RISE]);
   assign clear_flags = op.rd_data && sel_latch;

   always_comb begin
      rd = 8'd0;
      if (op.rd_data) begin
         rd = sel_latch ? ((pins & ~dir_ff) | (latch_ff & dir_ff)) : dir_ff;
      end else if (op.rd_ctl) begin
         rd = {flag1_ff, flag2_ff & ~ctl_ff[CTL_C2_OUT], ctl_ff};
      end
   end

   always_comb begin
      latch_in = latch_ff;
      dir_in   = dir_ff;
      ctl_in   = ctl_ff;
      drive_in = drive_ff;
      prev1_in = prev1_ff;
      prev2_in = prev2_ff;
      flag1_in = flag1_ff;
      flag2_in = flag2_ff;
      if (op.wr_data) begin
         if (sel_latch) latch_in = write_data;
         else dir_in = write_data;
      end
      if (op.wr_ctl) begin
         ctl_in = write_data[CTL_W-1:0];
         if (write_data[5:3] == C2_HIGH) drive_in = 1'b1;
         else if (write_data[5:3] == C2_LOW) drive_in = 1'b0;
      end
      if (op.strobe && sel_latch && (ctl_ff[5:4] == C2_STROBE_ANY)) begin
         drive_in = ctl_ff[CTL_C2_EN];
      end
      if (clear_flags) begin
         flag1_in = 1'b0;
         flag2_in = 1'b0;
      end
      if (op.pin_update) begin
         prev1_in = l1;
         prev2_in = l2;
         if (edge1) begin
            flag1_in = 1'b1;
            if (ctl_ff[5:3] == C2_STROBE) drive_in = 1'b1;
         end
         if (edge2) flag2_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
         dir_ff   <= '0;
         ctl_ff   <= '0;
         drive_ff <= 1'b0;
         prev1_ff <= 1'b0;
         prev2_ff <= 1'b0;
         flag1_ff <= 1'b0;
         flag2_ff <= 1'b0;
      end else if (step) begin
         latch_ff <= latch_in;
         dir_ff   <= dir_in;
         ctl_ff   <= ctl_in;
         drive_ff <= drive_in;
         prev1_ff <= prev1_in;
         prev2_ff <= prev2_in;
         flag1_ff <= flag1_in;
         flag2_ff <= flag2_in;
      end
   end

   always_comb begin
      res.read_data = rd;
      res.latch     = latch_in;
      res.dir       = dir_in;
      res.c2_drive  = drive_in;
      res.irq       = (flag1_in && ctl_in[CTL_C1_EN])
                      || (flag2_in && !ctl_in[CTL_C2_OUT] && ctl_in[CTL_C2_EN]);
   end

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      step && clear_flags |=> !flag1_ff && !flag2_ff)
      else $error("data read did not clear flags");

   a_levels_hold: assert property (@(posedge clock) disable iff (reset)
      !(step && op.pin_update) |=> $stable(prev1_ff) && $stable(prev2_ff))
      else $error("line levels changed without pin update");

   a_ctl_only_on_write: assert property (@(posedge clock) disable iff (reset)
      !(step && op.wr_ctl) |=> $stable(ctl_ff))
      else $error("control changed without control write");

endmodule

// ===== sv/parallel_port_adapter_with_handshake.sv =====
// Top level: request register, two port units, result register.
// The result is registered; a request moves on once the result register is empty or not stalled.
// Throughput: one request per cycle while the result side is not stalled.
// Port state updates when a request moves from the input register to the result register.
// Reset (synchronous, active high) clears all port registers and both valid flags.
module parallel_port_adapter_with_handshake (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ppa_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ppa_pkg::rsp_type rsp_payload
);
   import ppa_pkg::*;

   logic    s1_vld_ff, s1_vld_in;
   req_type s1_ff;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;
   logic    advance, step;

   port_op_type  op_a, op_b;
   port_out_type out_a, out_b;
   logic is_read, is_write;

   assign advance   = !rsp_vld_ff || !rsp_stall;
   assign step      = s1_vld_ff && advance;
   assign req_stall = s1_vld_ff && !advance;
   assign s1_vld_in = req_stall ? s1_vld_ff : req_valid;
   assign rsp_vld_in = advance ? s1_vld_ff : rsp_vld_ff;

   assign is_read  = (s1_ff.command == CMD_READ);
   assign is_write = (s1_ff.command == CMD_WRITE);

   always_comb begin
      op_a.rd_data    = is_read  && (s1_ff.reg_select == SEL_PORT_A);
      op_a.rd_ctl     = is_read  && (s1_ff.reg_select == SEL_CTL_A);
      op_a.wr_data    = is_write && (s1_ff.reg_select == SEL_PORT_A);
      op_a.wr_ctl     = is_write && (s1_ff.reg_select == SEL_CTL_A);
      op_a.pin_update = (s1_ff.command == CMD_PINS);
      op_a.strobe     = op_a.rd_data;
      op_b.rd_data    = is_read  && (s1_ff.reg_select == SEL_PORT_B);
      op_b.rd_ctl     = is_read  && (s1_ff.reg_select == SEL_CTL_B);
      op_b.wr_data    = is_write && (s1_ff.reg_select == SEL_PORT_B);
      op_b.wr_ctl     = is_write && (s1_ff.reg_select == SEL_CTL_B);
      op_b.pin_update = (s1_ff.command == CMD_PINS);
      op_b.strobe     = op_b.wr_data;
   end

   ppa_port u_port_a (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .op         (op_a),
      .write_data (s1_ff.write_data),
      .pins       (s1_ff.port_a_pins),
      .l1         (s1_ff.ca1_level),
      .l2         (s1_ff.ca2_level),
      .res        (out_a)
   );

   ppa_port u_port_b (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .op         (op_b),
      .write_data (s1_ff.write_data),
      .pins       (s1_ff.port_b_pins),
      .l1         (s1_ff.cb1_level),
      .l2         (s1_ff.cb2_level),
      .res        (out_b)
   );

   always_comb begin
      rsp_in.read_data        = out_a.read_data | out_b.read_data;
      rsp_in.port_a_latch     = out_a.latch;
      rsp_in.port_a_direction = out_a.dir;
      rsp_in.port_b_latch     = out_b.latch;
      rsp_in.port_b_direction = out_b.dir;
      rsp_in.ca2_drive        = out_a.c2_drive;
      rsp_in.cb2_drive        = out_b.c2_drive;
      rsp_in.irq_a_line       = out_a.irq;
      rsp_in.irq_b_line       = out_b.irq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) s1_ff <= req_payload;
      if (step) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff && rsp_vld_ff)
      else $error("request stalled with empty pipeline");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !advance |=> s1_vld_ff && $stable(s1_ff))
      else $error("pending request lost");

   a_zero_read_data: assert property (@(posedge clock) disable iff (reset)
      step && !is_read |=> rsp_ff.read_data == 8'd0)
      else $error("read data set on non-read request");

endmodule

// ===== dv/ppa_response_checker.sv =====
// Response checker for the parallel port adapter: predicts each response and compares it.
module ppa_response_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ppa_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ppa_pkg::rsp_type rsp_payload,
   output int               mismatch_count,
   output int               pending_count,
   output int               checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import ppa_pkg::*;

   logic [7:0]     latch_q [2];
   logic [7:0]     dir_q [2];
   logic [CTL_W-1:0] ctl_q [2];
   logic [1:0]     c2_drive_q;
   logic [3:0]     prev_lines_q;
   logic [3:0]     flags_q;
   rsp_type        expected_rsp_q [$];
   int             mismatches = 0;
   int             checked = 0;

   task automatic clear_port_state();
      for (int p = 0; p < 2; p++) begin
         latch_q[p] = '0;
         dir_q[p]   = '0;
         ctl_q[p]   = '0;
      end
      c2_drive_q   = '0;
      prev_lines_q = '0;
      flags_q      = '0;
   endtask

   // strobe and pulse modes both have bits 5..4 = 10; bit 3 picks pulse
   task automatic strobe_c2(input int p);
      if (ctl_q[p][CTL_C2_OUT:CTL_C2_RISE] == C2_STROBE_ANY)
         c2_drive_q[p] = ctl_q[p][CTL_C2_EN];
   endtask

   task automatic sense_lines(input int p, input logic l1, input logic l2);
      logic [CTL_W-1:0] c;
      c = ctl_q[p];
      if (l1 != prev_lines_q[p] && l1 == c[CTL_C1_RISE]) begin
         flags_q[2*p] = 1'b1;
         if (c[CTL_C2_OUT:CTL_C2_EN] == C2_STROBE)
            c2_drive_q[p] = 1'b1;
      end
      if (l2 != prev_lines_q[2+p] && !c[CTL_C2_OUT] && l2 == c[CTL_C2_RISE])
         flags_q[2*p+1] = 1'b1;
      prev_lines_q[p]   = l1;
      prev_lines_q[2+p] = l2;
   endtask

   function automatic logic port_irq(int p);
      return (flags_q[2*p] & ctl_q[p][CTL_C1_EN]) |
             (flags_q[2*p+1] & ~ctl_q[p][CTL_C2_OUT] & ctl_q[p][CTL_C2_EN]);
   endfunction

   task automatic predict_response(input req_type r, output rsp_type e);
      int         p;
      logic       is_ctl;
      logic [7:0] pins;
      logic [7:0] rd;
      p      = (r.reg_select == SEL_PORT_B || r.reg_select == SEL_CTL_B) ? 1 : 0;
      is_ctl = (r.reg_select == SEL_CTL_A || r.reg_select == SEL_CTL_B);
      pins   = (p == 0) ? r.port_a_pins : r.port_b_pins;
      rd     = '0;
      case (r.command)
         CMD_READ: begin
            if (is_ctl) begin
               rd = {flags_q[2*p], flags_q[2*p+1] & ~ctl_q[p][CTL_C2_OUT], ctl_q[p]};
            end else if (!ctl_q[p][CTL_DATA]) begin
               rd = dir_q[p];
            end else begin
               rd = (pins & ~dir_q[p]) | (latch_q[p] & dir_q[p]);
               flags_q[2*p +: 2] = 2'b00;
               if (p == 0) strobe_c2(0);
            end
         end
         CMD_WRITE: begin
            if (is_ctl) begin
               ctl_q[p] = r.write_data[CTL_W-1:0];
               if (ctl_q[p][CTL_C2_OUT:CTL_C2_EN] == C2_HIGH) c2_drive_q[p] = 1'b1;
               else if (ctl_q[p][CTL_C2_OUT:CTL_C2_EN] == C2_LOW) c2_drive_q[p] = 1'b0;
            end else if (ctl_q[p][CTL_DATA]) begin
               latch_q[p] = r.write_data;
               if (p == 1) strobe_c2(1);
            end else begin
               dir_q[p] = r.write_data;
            end
         end
         CMD_PINS: begin
            sense_lines(0, r.ca1_level, r.ca2_level);
            sense_lines(1, r.cb1_level, r.cb2_level);
         end
         default: ;
      endcase
      e.read_data        = rd;
      e.port_a_latch     = latch_q[0];
      e.port_a_direction = dir_q[0];
      e.port_b_latch     = latch_q[1];
      e.port_b_direction = dir_q[1];
      e.ca2_drive        = c2_drive_q[0];
      e.cb2_drive        = c2_drive_q[1];
      e.irq_a_line       = port_irq(0);
      e.irq_b_line       = port_irq(1);
   endtask

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      rsp_type next_rsp;
      if (reset) begin
         clear_port_state();
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               $display("%0t: response with none expected, expected none actual %0h",
                        $time, got);
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("read_data", want.read_data, got.read_data);
               compare_field("port_a_latch", want.port_a_latch, got.port_a_latch);
               compare_field("port_a_direction", want.port_a_direction,
                             got.port_a_direction);
               compare_field("port_b_latch", want.port_b_latch, got.port_b_latch);
               compare_field("port_b_direction", want.port_b_direction,
                             got.port_b_direction);
               compare_field("ca2_drive", 8'(want.ca2_drive), 8'(got.ca2_drive));
               compare_field("cb2_drive", 8'(want.cb2_drive), 8'(got.cb2_drive));
               compare_field("irq_a_line", 8'(want.irq_a_line), 8'(got.irq_a_line));
               compare_field("irq_b_line", 8'(want.irq_b_line), 8'(got.irq_b_line));
               checked++;
            end
         end
         if (req_valid && !req_stall) begin
            predict_response(req_payload, next_rsp);
            expected_rsp_q.push_back(next_rsp);
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_rsp_q.size();
      checked_count  <= checked;
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the parallel port adapter testbench: clock, reset, request stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ppa_pkg::*;

   localparam logic [1:0]  CMD_NOP         = 2'd3;
   localparam int unsigned WATCHDOG_LIMIT  = 2000;
   localparam int unsigned PHASE_REQUESTS  = 412;
   localparam int unsigned HOLD_OFF_CYCLES = 64;
   localparam int unsigned DRAIN_CYCLES    = 8;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   logic hold_off_arm     = 1'b0;
   logic hold_off_done    = 1'b0;
   int hold_off_left      = 0;
   int idle_cycles        = 0;
   int per_command [4]    = '{default: 0};

   always #6 clock = ~clock;

   parallel_port_adapter_with_handshake i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   ppa_response_checker i_response_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   // receiver: random stalls, or a counted hold-off once it is armed
   always @(posedge clock) begin
      if (hold_off_arm && !hold_off_done) begin
         rsp_stall     <= 1'b1;
         hold_off_done <= 1'b1;
         hold_off_left <= int'(HOLD_OFF_CYCLES) - 1;
      end else if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
   end

   // lines packs {ca1, cb1, ca2, cb2}
   function automatic req_type build_request(logic [1:0] cmd, logic [1:0] sel,
                                             logic [7:0] data, logic [7:0] pins_a,
                                             logic [7:0] pins_b, logic [3:0] lines);
      return {cmd, sel, data, pins_a, pins_b, lines};
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      r    = $urandom();
      pick = $urandom_range(99);
      if (pick < 33)      r.command = CMD_READ;
      else if (pick < 64) r.command = CMD_WRITE;
      else if (pick < 97) r.command = CMD_PINS;
      else                r.command = CMD_NOP;
      return r;
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      per_command[r.command]++;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // direction, data and control paths, port A
      send_request(build_request(CMD_WRITE, SEL_CTL_A, 8'h00, 8'h00, 8'h00, 4'b0000));
      send_request(build_request(CMD_WRITE, SEL_PORT_A, 8'hF0, 8'h00, 8'h00, 4'b0000));
      send_request(build_request(CMD_READ, SEL_PORT_A, 8'h00, 8'hFF, 8'hFF, 4'b0000));
      send_request(build_request(CMD_WRITE, SEL_CTL_A, 8'h07, 8'h00, 8'h00, 4'b0000));
      send_request(build_request(CMD_WRITE, SEL_PORT_A, 8'hFF, 8'h00, 8'h00, 4'b0000));
      send_request(build_request(CMD_READ, SEL_PORT_A, 8'h00, 8'h00, 8'h00, 4'b0000));
      // CA1 rising edge sets the flag, data read clears it
      send_request(build_request(CMD_PINS, SEL_PORT_A, 8'h00, 8'h00, 8'h00, 4'b1000));
      send_request(build_request(CMD_READ, SEL_CTL_A, 8'h00, 8'h00, 8'h00, 4'b1000));
      send_request(build_request(CMD_READ, SEL_PORT_A, 8'h00, 8'hFF, 8'h00, 4'b1000));
      // CA2 strobe restored by CA1, then pulse, low and high drive
      send_request(build_request(CMD_WRITE, SEL_CTL_A, 8'h27, 8'h00, 8'h00, 4'b1000));
      send_request(build_request(CMD_READ, SEL_PORT_A, 8'h00, 8'h5A, 8'h00, 4'b1000));
      send_request(build_request(CMD_PINS, SEL_PORT_A, 8'h00, 8'h00, 8'h00, 4'b0000));
      send_request(build_request(CMD_PINS, SEL_PORT_A, 8'h00, 8'h00, 8'h00, 4'b1000));
      send_request(build_request(CMD_WRITE, SEL_CTL_A, 8'h2C, 8'h00, 8'h00, 4'b1000));
      send_request(build_request(CMD_READ, SEL_PORT_A, 8'h00, 8'hA5, 8'h00, 4'b1000));
      send_request(build_request(CMD_WRITE, SEL_CTL_A, 8'h30, 8'h00, 8'h00, 4'b1000));
      send_request(build_request(CMD_WRITE, SEL_CTL_A, 8'hFF, 8'h00, 8'h00, 4'b1000));
      // CB2 input edge, then masked once CB2 becomes an output
      send_request(build_request(CMD_WRITE, SEL_CTL_B, 8'h1C, 8'h00, 8'h00, 4'b1000));
      send_request(build_request(CMD_PINS, SEL_PORT_B, 8'h00, 8'h00, 8'h00, 4'b1001));
      send_request(build_request(CMD_READ, SEL_CTL_B, 8'h00, 8'h00, 8'h00, 4'b1001));
      send_request(build_request(CMD_WRITE, SEL_CTL_B, 8'h3C, 8'h00, 8'h00, 4'b1001));
      send_request(build_request(CMD_READ, SEL_CTL_B, 8'h00, 8'h00, 8'h00, 4'b1001));
      // CB2 strobe on data write, restored by a falling CB1 edge
      send_request(build_request(CMD_WRITE, SEL_CTL_B, 8'h24, 8'h00, 8'h00, 4'b1001));
      send_request(build_request(CMD_WRITE, SEL_PORT_B, 8'h5A, 8'h00, 8'h00, 4'b1001));
      send_request(build_request(CMD_PINS, SEL_PORT_B, 8'h00, 8'h00, 8'h00, 4'b1100));
      send_request(build_request(CMD_PINS, SEL_PORT_B, 8'h00, 8'h00, 8'h00, 4'b0000));
      send_request(build_request(CMD_READ, SEL_PORT_B, 8'h00, 8'hFF, 8'hC3, 4'b0000));
      send_request(build_request(CMD_NOP, SEL_CTL_B, 8'hFF, 8'hFF, 8'hFF, 4'b1111));

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct = 45; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct <= 45; end
            default: begin sender_idle_pct = 20; receiver_stall_pct <= 20; end
         endcase
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (ph == 0 && n == 100)
               hold_off_arm <= 1'b1;
            send_request(random_request());
         end
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d reads, %0d writes, %0d pin updates and %0d no-op requests,",
               per_command[CMD_READ], per_command[CMD_WRITE], per_command[CMD_PINS],
               per_command[CMD_NOP]);
      $display("%0d responses checked under four idle mixes and a %0d-cycle response hold-off",
               checked_count, HOLD_OFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
